FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a plain property on every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: hdl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int COLS_DEF = 80;
    localparam int ROWS_DEF = 25;

    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 8;
    localparam int CELL_W  = 16;

    localparam logic [CHAR_W-1:0]  CH_SPACE    = 8'h20;
    localparam logic [CHAR_W-1:0]  CH_NL       = 8'd10;
    localparam logic [CHAR_W-1:0]  CH_CR       = 8'd13;
    localparam logic [CHAR_W-1:0]  CH_TAB      = 8'd9;
    localparam logic [COL_W:0]     TAB_STEP    = 8'd4;
    localparam logic [COLOR_W-1:0] COLOR_RESET = 8'h07;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        ACT_PUT   = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_SET   = 2'd2,
        ACT_READ  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        OP_NOP   = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_INIT  = 2'd0,
        ST_IDLE  = 2'd1,
        ST_READ  = 2'd2,
        ST_SWEEP = 2'd3
    } back_state_t;

    // One classified request for the back end.
    typedef struct packed {
        op_t               op;
        logic              scroll;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [CHAR_W-1:0] char_code;
        logic [COL_W-1:0]  cur_col;
        logic [ROW_W-1:0]  cur_row;
    } cmd_t;

    // Stall conditions seen by the front end.
    typedef struct packed {
        logic q_full;
        logic init_busy;
    } front_stall_t;

endpackage

FILE: hdl/tcw_channels.sv
// ----------------------------------------------------------------------------
// tcw channels
// Valid/ready interfaces for input requests and result requests.
// ----------------------------------------------------------------------------
interface tcw_item_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  action;
    logic [tcw_pkg::CHAR_W-1:0]  char_code;
    logic [tcw_pkg::COL_W-1:0]   pos_col;
    logic [tcw_pkg::ROW_W-1:0]   pos_row;

    modport source (output valid, output action, output char_code, output pos_col,
                    output pos_row, input ready);
    modport sink   (input valid, input action, input char_code, input pos_col,
                    input pos_row, output ready);
endinterface

interface tcw_result_if;
    logic                        valid;
    logic                        ready;
    logic [tcw_pkg::CELL_W-1:0]  cell_word;
    logic [tcw_pkg::COL_W-1:0]   cursor_col;
    logic [tcw_pkg::ROW_W-1:0]   cursor_row;

    modport source (output valid, output cell_word, output cursor_col, output cursor_row,
                    input ready);
    modport sink   (input valid, input cell_word, input cursor_col, input cursor_row,
                    output ready);
endinterface

FILE: hdl/tcw_front.sv
// ----------------------------------------------------------------------------
// tcw_front
// Accept requests, track the cursor and classify each into a back-end command.
// ----------------------------------------------------------------------------
module tcw_front #(
    parameter int COLS = tcw_pkg::COLS_DEF,
    parameter int ROWS = tcw_pkg::ROWS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    tcw_item_if.sink              item,
    input  tcw_pkg::front_stall_t stall,
    output logic                  push,
    output tcw_pkg::cmd_t         push_cmd
);

    logic [tcw_pkg::COL_W-1:0] cur_col_reg, cur_col_next;
    logic [tcw_pkg::ROW_W-1:0] cur_row_reg, cur_row_next;
    logic [tcw_pkg::COL_W:0]   col_step;
    logic [tcw_pkg::COL_W:0]   tab_sum;
    logic [tcw_pkg::ROW_W:0]   row_step;
    logic                      pos_ok;
    tcw_pkg::cmd_t             cmd;

    assign item.ready = !stall.q_full && !stall.init_busy;
    assign push       = item.valid && item.ready;
    assign push_cmd   = cmd;

    assign pos_ok  = ({1'b0, item.pos_col} < (tcw_pkg::COL_W + 1)'(COLS))
                  && ({1'b0, item.pos_row} < (tcw_pkg::ROW_W + 1)'(ROWS));
    assign tab_sum = {1'b0, cur_col_reg} + tcw_pkg::TAB_STEP;

    always_comb
    begin
        cmd           = '0;
        cmd.op        = tcw_pkg::OP_NOP;
        cmd.col       = cur_col_reg;
        cmd.row       = cur_row_reg;
        cmd.char_code = item.char_code;
        col_step      = {1'b0, cur_col_reg};
        row_step      = {1'b0, cur_row_reg};
        cur_col_next  = cur_col_reg;
        cur_row_next  = cur_row_reg;

        case (tcw_pkg::action_t'(item.action))
            tcw_pkg::ACT_PUT:
            begin
                case (item.char_code)
                    tcw_pkg::CH_NL:
                    begin
                        col_step = '0;
                        row_step = row_step + 1'b1;
                    end
                    tcw_pkg::CH_CR:
                    begin
                        col_step = '0;
                    end
                    tcw_pkg::CH_TAB:
                    begin
                        col_step = {tab_sum[tcw_pkg::COL_W:2], 2'b00};
                    end
                    default:
                    begin
                        cmd.op   = tcw_pkg::OP_WRITE;
                        col_step = col_step + 1'b1;
                    end
                endcase
                // wrap at line end, scroll past the last row
                if (col_step >= (tcw_pkg::COL_W + 1)'(COLS))
                begin
                    col_step = '0;
                    row_step = row_step + 1'b1;
                end
                if (row_step >= (tcw_pkg::ROW_W + 1)'(ROWS))
                begin
                    cmd.scroll = 1'b1;
                    row_step   = (tcw_pkg::ROW_W + 1)'(ROWS - 1);
                end
                cur_col_next = col_step[tcw_pkg::COL_W-1:0];
                cur_row_next = row_step[tcw_pkg::ROW_W-1:0];
            end
            tcw_pkg::ACT_CLEAR:
            begin
                cmd.op       = tcw_pkg::OP_CLEAR;
                cur_col_next = '0;
                cur_row_next = '0;
            end
            tcw_pkg::ACT_SET:
            begin
                if (pos_ok)
                begin
                    cur_col_next = item.pos_col;
                    cur_row_next = item.pos_row;
                end
            end
            tcw_pkg::ACT_READ:
            begin
                cmd.col = item.pos_col;
                cmd.row = item.pos_row;
                if (pos_ok)
                begin
                    cmd.op = tcw_pkg::OP_READ;
                end
            end
            default:
            begin
                cmd.op = tcw_pkg::OP_NOP;
            end
        endcase

        cmd.cur_col = cur_col_next;
        cmd.cur_row = cur_row_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_col_reg <= '0;
            cur_row_reg <= '0;
        end
        else if (push)
        begin
            cur_col_reg <= cur_col_next;
            cur_row_reg <= cur_row_next;
        end
    end

endmodule

FILE: hdl/tcw_cmd_queue.sv
// ----------------------------------------------------------------------------
// tcw_cmd_queue
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module tcw_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tcw_pkg::cmd_t push_cmd,
    input  logic          pop,
    output tcw_pkg::cmd_t pop_cmd,
    output logic          full,
    output logic          empty
);

    tcw_pkg::cmd_t                 entry_reg [tcw_pkg::QUEUE_DEPTH];
    logic [tcw_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [tcw_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [tcw_pkg::QUEUE_PTR_W:0]   count_reg, count_next;

    localparam logic [tcw_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
        tcw_pkg::QUEUE_PTR_W'(tcw_pkg::QUEUE_DEPTH - 1);

    assign full    = (count_reg == (tcw_pkg::QUEUE_PTR_W + 1)'(tcw_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: hdl/tcw_back.sv
// ----------------------------------------------------------------------------
// tcw_back
// Carry out commands on the cell memory and hold the result register.
// ----------------------------------------------------------------------------
module tcw_back #(
    parameter int COLS = tcw_pkg::COLS_DEF,
    parameter int ROWS = tcw_pkg::ROWS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [tcw_pkg::COLOR_W-1:0]  text_color,
    input  logic                         q_empty,
    input  tcw_pkg::cmd_t                q_cmd,
    output logic                         q_pop,
    output logic                         init_busy,
    tcw_result_if.source                 result
);

    localparam int CELLS  = COLS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLS);

    logic [tcw_pkg::CELL_W-1:0] mem [CELLS];

    tcw_pkg::back_state_t       state_reg, state_next;
    logic [tcw_pkg::ROW_W-1:0]  top_reg, top_next;
    logic [ADDR_W-1:0]          sweep_addr_reg, sweep_addr_next;
    logic [ADDR_W-1:0]          sweep_last_reg, sweep_last_next;
    logic [tcw_pkg::CELL_W-1:0] sweep_data_reg, sweep_data_next;
    logic                       out_valid_reg, out_valid_next;
    logic [tcw_pkg::CELL_W-1:0] cell_word_reg, cell_word_next;
    logic [tcw_pkg::COL_W-1:0]  cursor_col_reg, cursor_col_next;
    logic [tcw_pkg::ROW_W-1:0]  cursor_row_reg, cursor_row_next;
    logic [tcw_pkg::COL_W-1:0]  pend_col_reg, pend_col_next;
    logic [tcw_pkg::ROW_W-1:0]  pend_row_reg, pend_row_next;
    logic [tcw_pkg::CELL_W-1:0] rd_data_reg;

    logic                       mem_we;
    logic [ADDR_W-1:0]          mem_waddr;
    logic [tcw_pkg::CELL_W-1:0] mem_wdata;
    logic                       mem_re;

    logic [tcw_pkg::ROW_W:0]    row_sum;
    logic [tcw_pkg::ROW_W-1:0]  phys_row;
    logic [tcw_pkg::ROW_W-1:0]  top_inc;
    logic [ADDR_W-1:0]          cmd_addr;
    logic [ADDR_W-1:0]          top_base;
    logic [tcw_pkg::CELL_W-1:0] blank_cell;
    logic                       out_free;

    // map a screen row onto the rotating row store
    assign row_sum  = {1'b0, q_cmd.row} + {1'b0, top_reg};
    assign phys_row = (row_sum >= (tcw_pkg::ROW_W + 1)'(ROWS))
                    ? tcw_pkg::ROW_W'(row_sum - (tcw_pkg::ROW_W + 1)'(ROWS))
                    : row_sum[tcw_pkg::ROW_W-1:0];
    assign cmd_addr = ADDR_W'(phys_row) * COLS_A + ADDR_W'(q_cmd.col);
    assign top_base = ADDR_W'(top_reg) * COLS_A;
    assign top_inc  = (top_reg == tcw_pkg::ROW_W'(ROWS - 1)) ? '0 : top_reg + 1'b1;

    assign blank_cell = {text_color, tcw_pkg::CH_SPACE};
    assign out_free   = !out_valid_reg || result.ready;
    assign init_busy  = (state_reg == tcw_pkg::ST_INIT);

    assign result.valid      = out_valid_reg;
    assign result.cell_word  = cell_word_reg;
    assign result.cursor_col = cursor_col_reg;
    assign result.cursor_row = cursor_row_reg;

    always_comb
    begin
        state_next      = state_reg;
        top_next        = top_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_last_next = sweep_last_reg;
        sweep_data_next = sweep_data_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        cell_word_next  = cell_word_reg;
        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;
        pend_col_next   = pend_col_reg;
        pend_row_next   = pend_row_reg;
        q_pop           = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = sweep_addr_reg;
        mem_wdata       = sweep_data_reg;
        mem_re          = 1'b0;

        case (state_reg)
            tcw_pkg::ST_INIT, tcw_pkg::ST_SWEEP:
            begin
                mem_we          = 1'b1;
                sweep_addr_next = sweep_addr_reg + 1'b1;
                if (sweep_addr_reg == sweep_last_reg)
                begin
                    state_next = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_IDLE:
            begin
                if (!q_empty && out_free)
                begin
                    q_pop = 1'b1;
                    if (q_cmd.op != tcw_pkg::OP_READ)
                    begin
                        out_valid_next  = 1'b1;
                        cell_word_next  = '0;
                        cursor_col_next = q_cmd.cur_col;
                        cursor_row_next = q_cmd.cur_row;
                    end
                    case (q_cmd.op)
                        tcw_pkg::OP_WRITE:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = cmd_addr;
                            mem_wdata = {text_color, q_cmd.char_code};
                        end
                        tcw_pkg::OP_READ:
                        begin
                            mem_re        = 1'b1;
                            pend_col_next = q_cmd.cur_col;
                            pend_row_next = q_cmd.cur_row;
                            state_next    = tcw_pkg::ST_READ;
                        end
                        tcw_pkg::OP_CLEAR:
                        begin
                            sweep_addr_next = '0;
                            sweep_last_next = LAST_CELL;
                            sweep_data_next = blank_cell;
                            state_next      = tcw_pkg::ST_SWEEP;
                        end
                        default:
                        begin
                            mem_we = 1'b0;
                        end
                    endcase
                    // old top row becomes the new bottom line: blank it
                    if (q_cmd.scroll)
                    begin
                        top_next        = top_inc;
                        sweep_addr_next = top_base;
                        sweep_last_next = top_base + COLS_A - 1'b1;
                        sweep_data_next = blank_cell;
                        state_next      = tcw_pkg::ST_SWEEP;
                    end
                end
            end
            tcw_pkg::ST_READ:
            begin
                out_valid_next  = 1'b1;
                cell_word_next  = rd_data_reg;
                cursor_col_next = pend_col_reg;
                cursor_row_next = pend_row_reg;
                state_next      = tcw_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tcw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tcw_pkg::ST_INIT;
            top_reg        <= '0;
            sweep_addr_reg <= '0;
            sweep_last_reg <= LAST_CELL;
            sweep_data_reg <= {tcw_pkg::COLOR_RESET, tcw_pkg::CH_SPACE};
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            top_reg        <= top_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_last_reg <= sweep_last_next;
            sweep_data_reg <= sweep_data_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_word_reg  <= cell_word_next;
        cursor_col_reg <= cursor_col_next;
        cursor_row_reg <= cursor_row_next;
        pend_col_reg   <= pend_col_next;
        pend_row_reg   <= pend_row_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[cmd_addr];
        end
    end

endmodule

FILE: hdl/text_console_writer_core.sv
// ----------------------------------------------------------------------------
// text_console_writer_core
// Character-cell text console: cell store, cursor, control codes and scroll.
// ----------------------------------------------------------------------------
// Usage
//   item   : valid/ready input; each request puts a character, clears the
//            screen, sets the cursor or reads one cell.
//   result : valid/ready output; exactly one result request per input request,
//            carrying the cell read (zero unless a read) and the cursor after.
//   cfg_wr_en / cfg_wr_data : write the text colour; write only while idle.
// Path: an accepted request is written into the command queue; the back end
//   pops it and registers its result; a read first passes a registered memory read.
// Throughput: the back end retires one put, set or out-of-range request per
//   cycle while the result output is not stalled; a read waits in ST_READ
//   before the next request. A scroll also blanks the new bottom line and a clear
//   the whole store; both sweeps use the cell memory's single write port.
// Reset: the cell store is swept to a space in colour 0x07, one cell a cycle,
//   COLS*ROWS cells (2000 at 80x25); item.ready stays low until it is done.
// Stall: a stalled result is held in the output register; the two-entry
//   command queue keeps taking requests until it fills.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module text_console_writer_core #(
    parameter int COLS = tcw_pkg::COLS_DEF,
    parameter int ROWS = tcw_pkg::ROWS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [tcw_pkg::COLOR_W-1:0]  cfg_wr_data,
    tcw_item_if.sink                     item,
    tcw_result_if.source                 result
);

    // attribute for new and blanked cells
    logic [tcw_pkg::COLOR_W-1:0] text_color_reg;

    tcw_pkg::front_stall_t front_stall;
    tcw_pkg::cmd_t         q_push_cmd;
    tcw_pkg::cmd_t         q_pop_cmd;
    logic                  q_push;
    logic                  q_pop;
    logic                  q_full;
    logic                  q_empty;
    logic                  init_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg <= tcw_pkg::COLOR_RESET;
        end
        else if (cfg_wr_en)
        begin
            text_color_reg <= cfg_wr_data;
        end
    end

    // hold off the front end while the queue is full or the store is cleared after reset
    assign front_stall.q_full    = q_full;
    assign front_stall.init_busy = init_busy;

    // front end: take requests, advance the cursor, classify
    tcw_front #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .stall    (front_stall),
        .push     (q_push),
        .push_cmd (q_push_cmd)
    );

    // decouple the two halves so each may stall on its own
    tcw_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .pop      (q_pop),
        .pop_cmd  (q_pop_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    // back end: drive the cell memory, sweep lines, present results
    tcw_back #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_color (text_color_reg),
        .q_empty    (q_empty),
        .q_cmd      (q_pop_cmd),
        .q_pop      (q_pop),
        .init_busy  (init_busy),
        .result     (result)
    );

    // the front end must never push into a full queue
    `ASSERT_IMPLY(a_no_overflow, q_push, !q_full, "command pushed into full queue")
    // the back end must never pop an empty queue
    `ASSERT_IMPLY(a_no_underflow, q_pop, !q_empty, "command popped from empty queue")
    // the cursor reported with a result always lies on the screen
    `ASSERT_IMPLY(a_cursor_range, result.valid,
        ({1'b0, result.cursor_col} < (tcw_pkg::COL_W + 1)'(COLS))
        && ({1'b0, result.cursor_row} < (tcw_pkg::ROW_W + 1)'(ROWS)),
        "result cursor off screen")
    // no request may be taken while the store is still being cleared after reset
    `ASSERT_ALWAYS(a_no_accept_init, !(init_busy && item.valid && item.ready),
        "request accepted during reset clearing")

endmodule
